// ===== rtl/core/rbsi_pkg.sv =====
// Package for the ray versus box slab intersection block.
// Holds widths, register and status codes, and the divider pipeline word type.
// No dependencies.
package rbsi_pkg;

  localparam int unsigned COORD_WIDTH   = 32;
  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned EXT_WIDTH     = COORD_WIDTH - 1;
  localparam int unsigned NUM_WIDTH     = COORD_WIDTH + 2;
  localparam int unsigned CFG_IDX_WIDTH = 2;
  localparam int unsigned LANES         = 4;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_EXTENT_X = 2'd2,
    CFG_EXTENT_Y = 2'd3
  } cfg_idx_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_MISS   = 2'd0,
    ST_INSIDE = 2'd1,
    ST_HIT    = 2'd2
  } status_e;

  // One slab-time division in flight: partial remainder, dividend bits that
  // turn into quotient bits, overflow flag and result sign.
  typedef struct packed {
    logic [COORD_WIDTH-1:0] rem;
    logic [COORD_WIDTH-1:0] lo;
    logic                   sat;
    logic                   neg;
  } lane_t;

  // Word handed from cell to cell: both divisors and the four slab lanes.
  // Lanes 0 and 1 divide by den_x, lanes 2 and 3 by den_y.
  typedef struct packed {
    logic [COORD_WIDTH-1:0] den_x;
    logic [COORD_WIDTH-1:0] den_y;
    lane_t [LANES-1:0]      lane;
  } div_word_t;

endpackage

// ===== rtl/core/rbsi_if.sv =====
// Channel interfaces for the ray versus box slab intersection block.
// Depends on rbsi_pkg.

// Ray input channel.
interface rbsi_ray_if;
  logic                               valid;
  logic                               ready;
  logic [rbsi_pkg::COORD_WIDTH-1:0]   ray_start_x;
  logic [rbsi_pkg::COORD_WIDTH-1:0]   ray_start_y;
  logic [rbsi_pkg::COORD_WIDTH-1:0]   ray_dir_x;
  logic [rbsi_pkg::COORD_WIDTH-1:0]   ray_dir_y;
  modport source (output valid, ray_start_x, ray_start_y, ray_dir_x, ray_dir_y,
                  input ready);
  modport sink (input valid, ray_start_x, ray_start_y, ray_dir_x, ray_dir_y,
                output ready);
endinterface

// Result channel.
interface rbsi_res_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       hit_status;
  logic [rbsi_pkg::COORD_WIDTH-1:0] hit_time;
  modport source (output valid, hit_status, hit_time, input ready);
  modport sink (input valid, hit_status, hit_time, output ready);
endinterface

// Configuration write channel.
interface rbsi_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rbsi_pkg::CFG_IDX_WIDTH-1:0] index;
  logic [rbsi_pkg::COORD_WIDTH-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/ray_box_slab_intersect.sv =====
// Top level of the 2D ray versus axis-aligned box slab test.
// Depends on rbsi_pkg, rbsi_if, rbsi_div_cell and rbsi_resolve.
//
// Usage: the box is set through the cfg_i channel (index 0 center x, 1 center
// y, 2 extent x, 3 extent y), always ready, written while no ray is in flight.
// Each word on ray_i is one ray (origin and direction, signed Q16.16); each
// word on res_o is its status (miss, origin inside, hit ahead) and entry time.
// Stages: the prep register forms the slab numerators and divisors, a
// chain of 32 divider cells produces one quotient bit each for all four
// slab times, a further register saturates and signs, and the output register
// picks entry and exit and holds the result. One ray per cycle is taken while res_o is not stalled.
// The whole pipe advances together; when res_o holds a word that is not
// taken, the pipe freezes and ray_i.ready drops, and nothing is lost.
// Reset clears all valid bits and sets the box to center 0, extent 1.0.
module ray_box_slab_intersect (
  input  logic        clk_i,
  input  logic        rst_ni,
  rbsi_cfg_if.sink    cfg_i,
  rbsi_ray_if.sink    ray_i,
  rbsi_res_if.source  res_o
);

  localparam int unsigned CW = rbsi_pkg::COORD_WIDTH;
  localparam int unsigned NW = rbsi_pkg::NUM_WIDTH;
  localparam int unsigned FB = rbsi_pkg::FRAC_BITS;
  localparam int unsigned EW = rbsi_pkg::EXT_WIDTH;

  logic          en;
  logic [CW-1:0] center_x_q, center_y_q;
  logic [EW-1:0] extent_x_q, extent_y_q;

  logic                prep_valid_q;
  rbsi_pkg::div_word_t prep_word_q, prep_word_d;

  logic                chain_valid [CW+1];
  rbsi_pkg::div_word_t chain_word  [CW+1];

  // The pipe moves whenever the output register is free or being taken.
  assign en          = !res_o.valid || res_o.ready;
  assign ray_i.ready = en;
  assign cfg_i.ready = 1'b1;

  // Box configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      extent_x_q <= EW'(1) << FB;
      extent_y_q <= EW'(1) << FB;
    end else if (cfg_i.valid) begin
      unique case (rbsi_pkg::cfg_idx_e'(cfg_i.index))
        rbsi_pkg::CFG_CENTER_X: center_x_q <= cfg_i.data;
        rbsi_pkg::CFG_CENTER_Y: center_y_q <= cfg_i.data;
        rbsi_pkg::CFG_EXTENT_X: extent_x_q <= cfg_i.data[EW-1:0];
        rbsi_pkg::CFG_EXTENT_Y: extent_y_q <= cfg_i.data[EW-1:0];
        default: ;
      endcase
    end
  end

  // Slab numerators, divisor magnitudes, signs and the overflow pre-check.
  always_comb begin
    logic signed [NW-1:0] cx, cy, sx, sy, hx, hy;
    logic signed [NW-1:0] num [rbsi_pkg::LANES];
    logic [NW-1:0]        nabs, hi;
    logic [CW-1:0]        dx, dy, den;
    logic                 dneg;
    cx = {{(NW-CW){center_x_q[CW-1]}}, center_x_q};
    cy = {{(NW-CW){center_y_q[CW-1]}}, center_y_q};
    sx = {{(NW-CW){ray_i.ray_start_x[CW-1]}}, ray_i.ray_start_x};
    sy = {{(NW-CW){ray_i.ray_start_y[CW-1]}}, ray_i.ray_start_y};
    hx = NW'(extent_x_q >> 1);
    hy = NW'(extent_y_q >> 1);
    num[0] = cx - hx - sx;
    num[1] = cx + hx - sx;
    num[2] = cy - hy - sy;
    num[3] = cy + hy - sy;
    // A zero direction component becomes one positive LSB.
    dx = (ray_i.ray_dir_x == '0) ? CW'(1) : ray_i.ray_dir_x;
    dy = (ray_i.ray_dir_y == '0) ? CW'(1) : ray_i.ray_dir_y;
    prep_word_d.den_x = dx[CW-1] ? CW'(-dx) : dx;
    prep_word_d.den_y = dy[CW-1] ? CW'(-dy) : dy;
    for (int i = 0; i < rbsi_pkg::LANES; i++) begin
      den  = (i < 2) ? prep_word_d.den_x : prep_word_d.den_y;
      dneg = (i < 2) ? dx[CW-1] : dy[CW-1];
      nabs = num[i][NW-1] ? NW'(-num[i]) : NW'(num[i]);
      // The quotient fits CW bits only if the top dividend part is below den.
      hi   = nabs >> (CW - FB);
      prep_word_d.lane[i].sat = (hi >= NW'(den));
      prep_word_d.lane[i].rem = hi[CW-1:0];
      prep_word_d.lane[i].lo  = CW'(nabs << FB);
      prep_word_d.lane[i].neg = num[i][NW-1] ^ dneg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_valid_q <= 1'b0;
    end else if (en) begin
      prep_valid_q <= ray_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prep_word_q <= prep_word_d;
    end
  end

  // Divider chain, one quotient bit per cell.
  assign chain_valid[0] = prep_valid_q;
  assign chain_word[0]  = prep_word_q;

  for (genvar g = 0; g < CW; g++) begin : g_cell
    rbsi_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[g]),
      .word_i  (chain_word[g]),
      .valid_o (chain_valid[g+1]),
      .word_o  (chain_word[g+1])
    );
  end

  rbsi_resolve u_resolve (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (chain_valid[CW]),
    .word_i   (chain_word[CW]),
    .valid_o  (res_o.valid),
    .status_o (res_o.hit_status),
    .time_o   (res_o.hit_time)
  );

`ifndef SYNTHESIS
  // The status code never takes the unused value.
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.hit_status == rbsi_pkg::ST_MISS ||
                     res_o.hit_status == rbsi_pkg::ST_INSIDE ||
                     res_o.hit_status == rbsi_pkg::ST_HIT))
    else $error("illegal hit status");

  // A miss or an inside start reports time zero.
  a_time_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.hit_status != rbsi_pkg::ST_HIT) |-> (res_o.hit_time == '0))
    else $error("nonzero time without a hit");

  // A hit ahead never reports a negative entry time.
  a_hit_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.hit_status == rbsi_pkg::ST_HIT) |-> !res_o.hit_time[CW-1])
    else $error("negative entry time on a hit");
`endif

endmodule

// ===== rtl/core/rbsi_div_cell.sv =====
// One cell of the divider chain: one restoring quotient bit for all four lanes.
// Depends on rbsi_pkg.
module rbsi_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  rbsi_pkg::div_word_t word_i,
  output logic                valid_o,
  output rbsi_pkg::div_word_t word_o
);

  logic                valid_q;
  rbsi_pkg::div_word_t word_q, word_d;

  // Shift the next dividend bit into the remainder and try to subtract.
  always_comb begin
    logic [rbsi_pkg::COORD_WIDTH:0]   trial;
    logic [rbsi_pkg::COORD_WIDTH-1:0] den;
    logic                             qbit;
    word_d = word_i;
    for (int i = 0; i < rbsi_pkg::LANES; i++) begin
      den   = (i < 2) ? word_i.den_x : word_i.den_y;
      trial = {word_i.lane[i].rem, word_i.lane[i].lo[rbsi_pkg::COORD_WIDTH-1]};
      qbit  = (trial >= {1'b0, den});
      if (qbit) begin
        trial = trial - {1'b0, den};
      end
      word_d.lane[i].rem = trial[rbsi_pkg::COORD_WIDTH-1:0];
      word_d.lane[i].lo  = {word_i.lane[i].lo[rbsi_pkg::COORD_WIDTH-2:0], qbit};
    end
  end

  // Stage register; only the valid bit is reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== rtl/core/rbsi_resolve.sv =====
// Final stages: clamp and sign the four slab times, then entry, exit and status.
// Depends on rbsi_pkg.
module rbsi_resolve (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  rbsi_pkg::div_word_t                word_i,
  output logic                               valid_o,
  output logic [1:0]                         status_o,
  output logic [rbsi_pkg::COORD_WIDTH-1:0]   time_o
);

  localparam int unsigned CW = rbsi_pkg::COORD_WIDTH;

  logic                 t_valid_q;
  logic signed [CW-1:0] t_q [rbsi_pkg::LANES];
  logic signed [CW-1:0] t_d [rbsi_pkg::LANES];
  logic                 out_valid_q;
  logic [1:0]           status_q, status_d;
  logic [CW-1:0]        time_q, time_d;

  // Saturate each quotient to the signed range and apply the sign.
  always_comb begin
    logic [CW-1:0] limit;
    logic [CW-1:0] mag;
    for (int i = 0; i < rbsi_pkg::LANES; i++) begin
      limit = word_i.lane[i].neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      if (word_i.lane[i].sat || (word_i.lane[i].lo > limit)) begin
        mag = limit;
      end else begin
        mag = word_i.lane[i].lo;
      end
      t_d[i] = word_i.lane[i].neg ? signed'(-mag) : signed'(mag);
    end
  end

  // Entry is the later of the near slabs, exit the earlier of the far slabs.
  always_comb begin
    logic signed [CW-1:0] near_x, near_y, far_x, far_y, t_in, t_out;
    near_x = (t_q[0] < t_q[1]) ? t_q[0] : t_q[1];
    far_x  = (t_q[0] > t_q[1]) ? t_q[0] : t_q[1];
    near_y = (t_q[2] < t_q[3]) ? t_q[2] : t_q[3];
    far_y  = (t_q[2] > t_q[3]) ? t_q[2] : t_q[3];
    t_in   = (near_x > near_y) ? near_x : near_y;
    t_out  = (far_x < far_y) ? far_x : far_y;
    if ((t_in > t_out) || t_out[CW-1]) begin
      status_d = rbsi_pkg::ST_MISS;
      time_d   = '0;
    end else if (t_in[CW-1]) begin
      status_d = rbsi_pkg::ST_INSIDE;
      time_d   = '0;
    end else begin
      status_d = rbsi_pkg::ST_HIT;
      time_d   = t_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      t_valid_q   <= valid_i;
      out_valid_q <= t_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q      <= t_d;
      status_q <= status_d;
      time_q   <= time_d;
    end
  end

  assign valid_o  = out_valid_q;
  assign status_o = status_q;
  assign time_o   = time_q;

endmodule
